// File: src/pjp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjp_pkg
// Types, widths and step functions shared by the Plackett joint probability
// core: the front stages, the queue and the root/division back end.
// ----------------------------------------------------------------------------
package pjp_pkg;

  localparam int PROB_W  = 17;
  localparam int FRAC_W  = 16;
  localparam int ODDS_W  = 32;
  localparam int AMAG_W  = 50;
  localparam int HALF_W  = 25;
  localparam int PQ_W    = 33;
  localparam int TD_W    = 64;
  localparam int PP_W    = 65;
  localparam int NUM_W   = 65;
  localparam int ROOT_W  = 51;
  localparam int DISC_W  = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int DEN_W   = 52;
  localparam int QW      = 18;
  localparam int DREM_W  = DEN_W + 1;
  localparam int NHI_W   = NUM_W - QW;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;

  localparam logic [PROB_W-1:0] ONE_PROB       = 17'h10000;
  localparam logic [ODDS_W-1:0] ONE_ODDS       = 32'h0001_0000;
  localparam logic [AMAG_W-1:0] ONE_SQ         = 50'h1_0000_0000;
  localparam logic [DISC_W-1:0] DISC_ZERO_BAND = 102'd184467;

  localparam logic REG_MARGIN_TOL = 1'b0;
  localparam logic REG_ODDS_TOL   = 1'b1;

  typedef enum logic [1:0] {
    MODE_INDEP,
    MODE_UPPER,
    MODE_LOWER,
    MODE_ROOT
  } mode_t;

  typedef struct packed {
    logic              use_root;
    logic              status;
    logic [PROB_W-1:0] fixed_joint;
    logic [PROB_W-1:0] lower;
    logic [PROB_W-1:0] upper;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic              aneg;
    logic [AMAG_W-1:0] amag;
    logic [NUM_W-1:0]  num;
  } pl_t;

  typedef struct packed {
    pl_t               pl;
    logic [DISC_W-1:0] disc;
  } qent_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [QW-1:0]     q;
  } dv_t;

  function automatic sq_t sqrt_step(input logic [REM_W-1:0] rem,
                                    input logic [ROOT_W-1:0] root,
                                    input logic [1:0] pair);
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] trial;
    sq_t              o;
    r2    = {rem[REM_W-3:0], pair};
    trial = {root, 2'b01};
    if (r2 >= trial) begin
      o.rem  = r2 - trial;
      o.root = {root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_t div_step(input logic [DREM_W-1:0] rem,
                                   input logic [QW-1:0] q,
                                   input logic nb,
                                   input logic [DEN_W-1:0] den);
    logic [DREM_W-1:0] r2;
    logic [DREM_W-1:0] dx;
    dv_t               o;
    r2 = {rem[DREM_W-2:0], nb};
    dx = {1'b0, den};
    if (r2 >= dx) begin
      o.rem = r2 - dx;
      o.q   = {q[QW-2:0], 1'b1};
    end else begin
      o.rem = r2;
      o.q   = {q[QW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// File: src/pjp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjp_front
// Six-stage front end: saturates the margins, classifies the item, resolves
// the closed-form cases and builds the discriminant of the Plackett quadratic.
// ----------------------------------------------------------------------------
module pjp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pjp_pkg::PROB_W-1:0]  in_prob_first,
  input  logic [pjp_pkg::PROB_W-1:0]  in_prob_second,
  input  logic [pjp_pkg::ODDS_W-1:0]  in_odds_ratio,
  input  logic                        in_odds_infinite,
  input  logic [pjp_pkg::PROB_W-1:0]  margin_lim,
  input  logic [pjp_pkg::PROB_W-1:0]  odds_tol,
  output logic                        push,
  output pjp_pkg::qent_t              push_data,
  input  logic                        q_full
);

  logic fe_en;
  logic accept;
  logic [5:0] v_r;

  logic [pjp_pkg::PROB_W-1:0] f0_q1_r, f0_q2_r;
  logic [pjp_pkg::ODDS_W-1:0] f0_t_r;
  logic                       f0_inf_r;

  logic [pjp_pkg::PROB_W-1:0] f1_lower_r, f1_upper_r;
  logic [pjp_pkg::PQ_W-1:0]   f1_pq_r;
  logic [pjp_pkg::PROB_W:0]   f1_s_r;
  logic [pjp_pkg::ODDS_W-1:0] f1_d_r, f1_t_r;
  logic                       f1_above_r;
  pjp_pkg::mode_t             f1_mode_r;

  pjp_pkg::side_t             f2_side_r;
  logic [pjp_pkg::AMAG_W-1:0] f2_amag_r;
  logic                       f2_aneg_r, f2_above_r;
  logic [pjp_pkg::TD_W-1:0]   f2_td_r;
  logic [pjp_pkg::PQ_W-1:0]   f2_pq_r;
  logic [pjp_pkg::ODDS_W-1:0] f2_t_r;

  pjp_pkg::side_t               f3_side_r;
  logic [pjp_pkg::AMAG_W-1:0]   f3_amag_r;
  logic                         f3_aneg_r, f3_above_r;
  logic [2*pjp_pkg::HALF_W-1:0] f3_hh_r, f3_hl_r, f3_ll_r;
  logic [pjp_pkg::PP_W-1:0]     f3_tph_r, f3_tpl_r;
  logic [pjp_pkg::NUM_W-1:0]    f3_num_r;

  pjp_pkg::side_t             f4_side_r;
  logic [pjp_pkg::AMAG_W-1:0] f4_amag_r;
  logic                       f4_aneg_r, f4_above_r;
  logic [pjp_pkg::DISC_W-1:0] f4_a2_r, f4_term_r;
  logic [pjp_pkg::NUM_W-1:0]  f4_num_r;

  pjp_pkg::qent_t f5_ent_r;

  logic [pjp_pkg::PROB_W-1:0] q1_sat, q2_sat;
  logic [pjp_pkg::PROB_W:0]   sum, lo_full;
  logic [pjp_pkg::PROB_W-1:0] lower, upper, c1, c2, bd;
  logic [pjp_pkg::ODDS_W-1:0] odds_dist;
  logic [2*pjp_pkg::PROB_W-1:0] pq_full;
  pjp_pkg::mode_t             mode;

  logic [pjp_pkg::AMAG_W-1:0] sd, amag;
  logic                       aneg;
  logic [pjp_pkg::TD_W-1:0]   td;
  logic [pjp_pkg::PQ_W:0]     pq_rnd;
  pjp_pkg::side_t             side2;

  logic [pjp_pkg::HALF_W-1:0] ah, al;
  logic [pjp_pkg::PP_W-1:0]   tpq;

  logic [pjp_pkg::DISC_W-1:0] a2, term;
  pjp_pkg::qent_t             ent5;
  logic [pjp_pkg::DISC_W-1:0] gap;

  assign fe_en    = !(v_r[5] && q_full);
  assign in_stall = !fe_en;
  assign accept   = in_valid && fe_en;
  assign push     = v_r[5] && !q_full;
  assign push_data = f5_ent_r;

  assign q1_sat = (in_prob_first > pjp_pkg::ONE_PROB) ? pjp_pkg::ONE_PROB : in_prob_first;
  assign q2_sat = (in_prob_second > pjp_pkg::ONE_PROB) ? pjp_pkg::ONE_PROB : in_prob_second;

  always_comb begin
    sum     = {1'b0, f0_q1_r} + {1'b0, f0_q2_r};
    lo_full = sum - {1'b0, pjp_pkg::ONE_PROB};
    lower   = (sum > {1'b0, pjp_pkg::ONE_PROB}) ? lo_full[pjp_pkg::PROB_W-1:0] : '0;
    upper   = (f0_q1_r < f0_q2_r) ? f0_q1_r : f0_q2_r;
    c1      = pjp_pkg::ONE_PROB - f0_q1_r;
    c2      = pjp_pkg::ONE_PROB - f0_q2_r;
    bd      = (f0_q1_r < c1) ? f0_q1_r : c1;
    if (f0_q2_r < bd) begin
      bd = f0_q2_r;
    end
    if (c2 < bd) begin
      bd = c2;
    end
    odds_dist = (f0_t_r >= pjp_pkg::ONE_ODDS) ? f0_t_r - pjp_pkg::ONE_ODDS
                                              : pjp_pkg::ONE_ODDS - f0_t_r;
    pq_full = f0_q1_r * f0_q2_r;
    if (bd < margin_lim || (!f0_inf_r && odds_dist < {15'b0, odds_tol})) begin
      mode = pjp_pkg::MODE_INDEP;
    end else if (f0_inf_r) begin
      mode = pjp_pkg::MODE_UPPER;
    end else if (f0_t_r == '0) begin
      mode = pjp_pkg::MODE_LOWER;
    end else begin
      mode = pjp_pkg::MODE_ROOT;
    end
  end

  always_comb begin
    sd = f1_s_r * f1_d_r;
    aneg = 1'b0;
    if (f1_above_r) begin
      amag = pjp_pkg::ONE_SQ + sd;
    end else if (sd > pjp_pkg::ONE_SQ) begin
      amag = sd - pjp_pkg::ONE_SQ;
      aneg = 1'b1;
    end else begin
      amag = pjp_pkg::ONE_SQ - sd;
    end
    td     = f1_t_r * f1_d_r;
    pq_rnd = {1'b0, f1_pq_r} + 34'h0_0000_8000;
    side2.lower    = f1_lower_r;
    side2.upper    = f1_upper_r;
    side2.status   = 1'b0;
    side2.use_root = 1'b0;
    case (f1_mode_r)
      pjp_pkg::MODE_INDEP: side2.fixed_joint = pq_rnd[pjp_pkg::PQ_W-1:pjp_pkg::FRAC_W];
      pjp_pkg::MODE_UPPER: side2.fixed_joint = f1_upper_r;
      pjp_pkg::MODE_LOWER: side2.fixed_joint = f1_lower_r;
      pjp_pkg::MODE_ROOT: begin
        side2.fixed_joint = '0;
        side2.use_root    = 1'b1;
      end
      default: side2.fixed_joint = '0;
    endcase
  end

  assign ah  = f2_amag_r[pjp_pkg::AMAG_W-1:pjp_pkg::HALF_W];
  assign al  = f2_amag_r[pjp_pkg::HALF_W-1:0];
  assign tpq = f2_t_r * f2_pq_r;

  always_comb begin
    a2 = (pjp_pkg::DISC_W'(f3_hh_r) << (2 * pjp_pkg::HALF_W))
       + (pjp_pkg::DISC_W'(f3_hl_r) << (pjp_pkg::HALF_W + 1))
       + pjp_pkg::DISC_W'(f3_ll_r);
    term = ((pjp_pkg::DISC_W'(f3_tph_r) << 32) + pjp_pkg::DISC_W'(f3_tpl_r)) << 2;
  end

  always_comb begin
    ent5.pl.side = f4_side_r;
    ent5.pl.aneg = f4_aneg_r;
    ent5.pl.amag = f4_amag_r;
    ent5.pl.num  = f4_num_r;
    gap = f4_term_r - f4_a2_r;
    if (!f4_above_r) begin
      ent5.disc = f4_a2_r + f4_term_r;
    end else if (f4_term_r <= f4_a2_r) begin
      ent5.disc = f4_a2_r - f4_term_r;
    end else begin
      ent5.disc = '0;
      if (gap >= pjp_pkg::DISC_ZERO_BAND && f4_side_r.use_root) begin
        ent5.pl.side.use_root    = 1'b0;
        ent5.pl.side.status      = 1'b1;
        ent5.pl.side.fixed_joint = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (fe_en) begin
      v_r <= {v_r[4:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (fe_en) begin
      f0_q1_r  <= q1_sat;
      f0_q2_r  <= q2_sat;
      f0_t_r   <= in_odds_ratio;
      f0_inf_r <= in_odds_infinite;

      f1_lower_r <= lower;
      f1_upper_r <= upper;
      f1_pq_r    <= pq_full[pjp_pkg::PQ_W-1:0];
      f1_s_r     <= sum;
      f1_d_r     <= odds_dist;
      f1_t_r     <= f0_t_r;
      f1_above_r <= (f0_t_r >= pjp_pkg::ONE_ODDS);
      f1_mode_r  <= mode;

      f2_side_r  <= side2;
      f2_amag_r  <= amag;
      f2_aneg_r  <= aneg;
      f2_above_r <= f1_above_r;
      f2_td_r    <= td;
      f2_pq_r    <= f1_pq_r;
      f2_t_r     <= f1_t_r;

      f3_side_r  <= f2_side_r;
      f3_amag_r  <= f2_amag_r;
      f3_aneg_r  <= f2_aneg_r;
      f3_above_r <= f2_above_r;
      f3_hh_r    <= ah * ah;
      f3_hl_r    <= ah * al;
      f3_ll_r    <= al * al;
      f3_tph_r   <= f2_td_r[63:32] * f2_pq_r;
      f3_tpl_r   <= f2_td_r[31:0] * f2_pq_r;
      f3_num_r   <= {tpq[pjp_pkg::NUM_W-2:0], 1'b0};

      f4_side_r  <= f3_side_r;
      f4_amag_r  <= f3_amag_r;
      f4_aneg_r  <= f3_aneg_r;
      f4_above_r <= f3_above_r;
      f4_a2_r    <= a2;
      f4_term_r  <= term;
      f4_num_r   <= f3_num_r;

      f5_ent_r <= ent5;
    end
  end

endmodule

// File: src/pjp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjp_fifo
// Four-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module pjp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pjp_pkg::qent_t push_data,
  output logic           full,
  input  logic           pop,
  output pjp_pkg::qent_t pop_data,
  output logic           empty
);

  pjp_pkg::qent_t              mem_r [pjp_pkg::QDEPTH];
  logic [pjp_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [pjp_pkg::QPTR_W:0]    count_r;

  assign full     = (count_r == (pjp_pkg::QPTR_W + 1)'(pjp_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue read while empty");

endmodule

// File: src/pjp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjp_back
// Back end: bit-per-stage square root of the discriminant, denominator,
// bit-per-stage quotient, rounding, clamping and the output register.
// ----------------------------------------------------------------------------
module pjp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  pjp_pkg::qent_t             q_data,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pjp_pkg::PROB_W-1:0] out_joint_prob,
  output logic                       out_status
);

  localparam int RW = pjp_pkg::ROOT_W;
  localparam int QW = pjp_pkg::QW;

  logic be_en;

  logic [RW-1:0]              sq_v_r;
  pjp_pkg::sq_t               sq_r    [RW];
  logic [pjp_pkg::DISC_W-1:0] sq_d_r  [RW];
  pjp_pkg::pl_t               sq_pl_r [RW];

  logic                       dn_v_r;
  logic [pjp_pkg::DEN_W-1:0]  dn_den_r;
  pjp_pkg::pl_t               dn_pl_r;

  logic                       ini_v_r, ini_dz_r, ini_ovf_r;
  logic [pjp_pkg::DEN_W-1:0]  ini_den_r;
  logic [pjp_pkg::DREM_W-1:0] ini_rem_r;
  pjp_pkg::pl_t               ini_pl_r;

  logic [QW-1:0]              dv_v_r;
  pjp_pkg::dv_t               dv_r     [QW];
  logic [pjp_pkg::DEN_W-1:0]  dv_den_r [QW];
  pjp_pkg::pl_t               dv_pl_r  [QW];
  logic [QW-1:0]              dv_dz_r, dv_ovf_r;

  logic                       fin_v_r, fin_status_r;
  logic [pjp_pkg::PROB_W-1:0] fin_joint_r;

  logic [pjp_pkg::DEN_W-1:0]  r_ext, a_ext, den;
  logic [pjp_pkg::NHI_W-1:0]  num_hi;
  pjp_pkg::dv_t               last;
  pjp_pkg::pl_t               lpl;
  logic [pjp_pkg::DREM_W:0]   twice;
  logic [QW:0]                qr, v, lo_e, up_e;
  logic [pjp_pkg::PROB_W-1:0] joint;

  assign be_en          = !(fin_v_r && out_stall);
  assign pop            = !q_empty && be_en;
  assign out_valid      = fin_v_r;
  assign out_joint_prob = fin_joint_r;
  assign out_status     = fin_status_r;

  always_comb begin
    r_ext = pjp_pkg::DEN_W'(sq_r[RW-1].root);
    a_ext = pjp_pkg::DEN_W'(sq_pl_r[RW-1].amag);
    if (sq_pl_r[RW-1].aneg) begin
      den = (r_ext > a_ext) ? r_ext - a_ext : '0;
    end else begin
      den = a_ext + r_ext;
    end
    num_hi = dn_pl_r.num[pjp_pkg::NUM_W-1:QW];
  end

  always_comb begin
    last  = dv_r[QW-1];
    lpl   = dv_pl_r[QW-1];
    twice = {last.rem, 1'b0};
    qr    = {1'b0, last.q};
    if (twice >= {2'b0, dv_den_r[QW-1]}) begin
      qr = qr + 1'b1;
    end
    lo_e = (QW + 1)'(lpl.side.lower);
    up_e = (QW + 1)'(lpl.side.upper);
    if (dv_dz_r[QW-1]) begin
      v = '0;
    end else if (dv_ovf_r[QW-1]) begin
      v = up_e;
    end else begin
      v = qr;
    end
    if (v < lo_e) begin
      v = lo_e;
    end
    if (v > up_e) begin
      v = up_e;
    end
    joint = lpl.side.use_root ? v[pjp_pkg::PROB_W-1:0] : lpl.side.fixed_joint;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r  <= '0;
      dn_v_r  <= 1'b0;
      ini_v_r <= 1'b0;
      dv_v_r  <= '0;
      fin_v_r <= 1'b0;
    end else if (be_en) begin
      sq_v_r  <= {sq_v_r[RW-2:0], !q_empty};
      dn_v_r  <= sq_v_r[RW-1];
      ini_v_r <= dn_v_r;
      dv_v_r  <= {dv_v_r[QW-2:0], ini_v_r};
      fin_v_r <= dv_v_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (be_en) begin
      sq_r[0]    <= pjp_pkg::sqrt_step('0, '0, q_data.disc[pjp_pkg::DISC_W-1 -: 2]);
      sq_d_r[0]  <= q_data.disc << 2;
      sq_pl_r[0] <= q_data.pl;
      for (int i = 1; i < RW; i++) begin
        sq_r[i]    <= pjp_pkg::sqrt_step(sq_r[i-1].rem, sq_r[i-1].root,
                                         sq_d_r[i-1][pjp_pkg::DISC_W-1 -: 2]);
        sq_d_r[i]  <= sq_d_r[i-1] << 2;
        sq_pl_r[i] <= sq_pl_r[i-1];
      end

      dn_den_r <= den;
      dn_pl_r  <= sq_pl_r[RW-1];

      ini_den_r <= dn_den_r;
      ini_pl_r  <= dn_pl_r;
      ini_dz_r  <= (dn_den_r == '0);
      ini_ovf_r <= (pjp_pkg::DEN_W'(num_hi) >= dn_den_r);
      ini_rem_r <= pjp_pkg::DREM_W'(num_hi);

      dv_r[0]     <= pjp_pkg::div_step(ini_rem_r, '0, ini_pl_r.num[QW-1], ini_den_r);
      dv_den_r[0] <= ini_den_r;
      dv_pl_r[0]  <= ini_pl_r;
      dv_dz_r[0]  <= ini_dz_r;
      dv_ovf_r[0] <= ini_ovf_r;
      for (int j = 1; j < QW; j++) begin
        dv_r[j]     <= pjp_pkg::div_step(dv_r[j-1].rem, dv_r[j-1].q,
                                         dv_pl_r[j-1].num[QW-1-j], dv_den_r[j-1]);
        dv_den_r[j] <= dv_den_r[j-1];
        dv_pl_r[j]  <= dv_pl_r[j-1];
        dv_dz_r[j]  <= dv_dz_r[j-1];
        dv_ovf_r[j] <= dv_ovf_r[j-1];
      end

      fin_joint_r  <= joint;
      fin_status_r <= lpl.side.status;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_joint_prob == '0)
    else $error("error result carries a nonzero probability");
  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_joint_prob <= pjp_pkg::ONE_PROB)
    else $error("joint probability above one");

endmodule

// File: src/plackett_joint_prob_with_tolerances_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plackett_joint_prob_with_tolerances_core
// Joint probability P(1,1) of the Plackett distribution with Bernoulli margins.
// ----------------------------------------------------------------------------
// Path from an accepted input beat to its result beat: six front stages, the
// queue, 51 square-root stages, the denominator, the divider set-up, the
// division stages and the output register. Throughput: one beat per cycle
// unless stalled; output stall holds the whole back end, a full queue the front.
// Reset clears all valid state and sets both tolerances to one LSB.
module plackett_joint_prob_with_tolerances_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [pjp_pkg::PROB_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pjp_pkg::PROB_W-1:0] in_prob_first,
  input  logic [pjp_pkg::PROB_W-1:0] in_prob_second,
  input  logic [pjp_pkg::ODDS_W-1:0] in_odds_ratio,
  input  logic                       in_odds_infinite,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pjp_pkg::PROB_W-1:0] out_joint_prob,
  output logic                       out_status
);

  logic [pjp_pkg::PROB_W-1:0] margin_lim_r, odds_tol_r;
  logic                       push, q_full, q_empty, pop;
  pjp_pkg::qent_t             push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_lim_r <= pjp_pkg::PROB_W'(1);
      odds_tol_r   <= pjp_pkg::PROB_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        pjp_pkg::REG_MARGIN_TOL: margin_lim_r <= cfg_wdata;
        pjp_pkg::REG_ODDS_TOL:   odds_tol_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pjp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_prob_first    (in_prob_first),
    .in_prob_second   (in_prob_second),
    .in_odds_ratio    (in_odds_ratio),
    .in_odds_infinite (in_odds_infinite),
    .margin_lim       (margin_lim_r),
    .odds_tol         (odds_tol_r),
    .push             (push),
    .push_data        (push_data),
    .q_full           (q_full)
  );

  pjp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  pjp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_joint_prob (out_joint_prob),
    .out_status     (out_status)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Plackett joint probability core. Directed
// corner beats run first, then random beats under several tolerance settings.
// Both ports idle and stall in random bursts. A scoreboard predicts each
// result with exact wide integer arithmetic and checks results in order.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [pjp_pkg::PROB_W-1:0] p1;
    logic [pjp_pkg::PROB_W-1:0] p2;
    logic [pjp_pkg::ODDS_W-1:0] theta;
    logic                       inf;
  } pair_beat_t;

  typedef struct {
    logic [pjp_pkg::PROB_W-1:0] joint;
    logic                       status;
  } joint_res_t;

  class joint_scoreboard;
    logic [pjp_pkg::PROB_W-1:0] margin_lim;
    logic [pjp_pkg::PROB_W-1:0] odds_tol;
    joint_res_t                 pending[$];
    int                         mismatches;

    function new();
      margin_lim = 17'd1;
      odds_tol   = 17'd1;
      mismatches = 0;
    endfunction

    function automatic joint_res_t plackett_joint(pair_beat_t b);
      logic [63:0]  q1, q2, t, lo_b, up_b, bd, odds_dist, s, pq, d, amag, r, den, q, jv;
      logic [127:0] a2, term, disc, num, gap, c, q128, rem;
      logic         above, aneg;
      joint_res_t   res;
      q1 = 64'(b.p1);
      q2 = 64'(b.p2);
      t = 64'(b.theta);
      aneg = 1'b0;
      res.status = 1'b0;
      jv = '0;
      if (q1 > 65536) q1 = 65536;
      if (q2 > 65536) q2 = 65536;
      lo_b = (q1 + q2 > 65536) ? q1 + q2 - 65536 : 0;
      up_b = (q1 < q2) ? q1 : q2;
      bd = (q1 < 65536 - q1) ? q1 : 65536 - q1;
      if (q2 < bd) bd = q2;
      if (65536 - q2 < bd) bd = 65536 - q2;
      odds_dist = (t >= 65536) ? t - 65536 : 65536 - t;
      if (bd < 64'(margin_lim) || (!b.inf && odds_dist < 64'(odds_tol))) begin
        jv = (q1 * q2 + 32768) >> 16;
      end else if (b.inf) begin
        jv = up_b;
      end else if (t == 0) begin
        jv = lo_b;
      end else begin
        s = q1 + q2;
        pq = q1 * q2;
        above = (t >= 65536);
        if (above) begin
          d = t - 65536;
          amag = 64'h1_0000_0000 + s * d;
        end else begin
          d = 65536 - t;
          if (64'h1_0000_0000 >= s * d) amag = 64'h1_0000_0000 - s * d;
          else begin
            amag = s * d - 64'h1_0000_0000;
            aneg = 1'b1;
          end
        end
        a2 = 128'(amag) * 128'(amag);
        term = (128'(t * d) * 128'(pq)) << 2;
        if (!above) disc = a2 + term;
        else if (term <= a2) disc = a2 - term;
        else begin
          gap = term - a2;
          if (gap >= 128'd184467) res.status = 1'b1;
          disc = '0;
        end
        if (!res.status) begin
          r = 0;
          for (int i = 63; i >= 0; i--) begin
            c = 128'(r | (64'd1 << i));
            if (c * c <= disc) r = c[63:0];
          end
          if (aneg) den = (r > amag) ? r - amag : 0;
          else den = amag + r;
          if (den == 0) q = 0;
          else begin
            num = (128'(t) * 128'(pq)) << 1;
            q128 = num / 128'(den);
            q = (q128 > 128'(MAX64)) ? MAX64 : q128[63:0];
            rem = num - 128'(q) * 128'(den);
            if (rem[63:0] >= den - rem[63:0] && q != MAX64) q = q + 1;
          end
          if (q < lo_b) q = lo_b;
          if (q > up_b) q = up_b;
          jv = q;
        end
      end
      res.joint = jv[pjp_pkg::PROB_W-1:0];
      return res;
    endfunction

    function void note_input(pair_beat_t b);
      pending.push_back(plackett_joint(b));
    endfunction

    function void check_result(logic [pjp_pkg::PROB_W-1:0] joint, logic status);
      joint_res_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: joint %0d status %0d", joint, status);
        return;
      end
      exp_r = pending.pop_front();
      if (joint !== exp_r.joint || status !== exp_r.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected joint %0d status %0d, got joint %0d status %0d",
                   exp_r.joint, exp_r.status, joint, status);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we, cfg_index;
  logic [pjp_pkg::PROB_W-1:0] cfg_wdata;
  logic in_valid, in_stall, in_odds_infinite;
  logic [pjp_pkg::PROB_W-1:0] in_prob_first, in_prob_second;
  logic [pjp_pkg::ODDS_W-1:0] in_odds_ratio;
  logic out_valid, out_stall, out_status;
  logic [pjp_pkg::PROB_W-1:0] out_joint_prob;

  joint_scoreboard sb;
  bit quiet;
  int idle_cycles;

  plackett_joint_prob_with_tolerances_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_prob_first(in_prob_first), .in_prob_second(in_prob_second),
    .in_odds_ratio(in_odds_ratio), .in_odds_infinite(in_odds_infinite),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_joint_prob(out_joint_prob), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_joint_prob, out_status);
    if (rst_n && ((out_valid && !out_stall) || (in_valid && !in_stall))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("plackett_joint_prob_with_tolerances_core test failed");
      $finish;
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      if (quiet || $urandom_range(0, 1)) begin
        n = $urandom_range(1, 20);
        repeat (n) @(negedge clk) out_stall <= 1'b0;
      end else begin
        n = $urandom_range(1, 13);
        repeat (n) @(negedge clk) out_stall <= 1'b1;
      end
    end
  end

  task automatic send_beat(pair_beat_t b);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk) in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_prob_first <= b.p1;
    in_prob_second <= b.p2;
    in_odds_ratio <= b.theta;
    in_odds_infinite <= b.inf;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
  endtask

  task automatic write_tolerances(logic [pjp_pkg::PROB_W-1:0] mt,
                                  logic [pjp_pkg::PROB_W-1:0] ot);
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= pjp_pkg::REG_MARGIN_TOL;
    cfg_wdata <= mt;
    @(negedge clk);
    cfg_index <= pjp_pkg::REG_ODDS_TOL;
    cfg_wdata <= ot;
    @(negedge clk) cfg_we <= 1'b0;
    sb.margin_lim = mt;
    sb.odds_tol = ot;
  endtask

  function automatic logic [pjp_pkg::PROB_W-1:0] rand_prob();
    case ($urandom_range(0, 9))
      0: return pjp_pkg::PROB_W'($urandom_range(0, 40));
      1: return pjp_pkg::PROB_W'($urandom_range(65496, 65536));
      2: return pjp_pkg::PROB_W'($urandom_range(65537, 131071));
      default: return pjp_pkg::PROB_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic pair_beat_t rand_beat();
    pair_beat_t b;
    b.p1 = rand_prob();
    b.p2 = rand_prob();
    b.inf = ($urandom_range(0, 11) == 0);
    case ($urandom_range(0, 9))
      0: b.theta = 0;
      1: b.theta = $urandom_range(65536 - 3000, 65536 + 3000);
      2: b.theta = $urandom_range(1, 65535);
      3: b.theta = $urandom;
      4: b.theta = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h1;
      default: b.theta = $urandom_range(65537, 64 * 65536);
    endcase
    return b;
  endfunction

  initial begin
    logic [pjp_pkg::PROB_W-1:0] corner[6];
    pair_beat_t b;
    logic [pjp_pkg::PROB_W-1:0] mts[6], ots[6];
    sb = new();
    quiet = 1'b0;
    idle_cycles = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = pjp_pkg::REG_MARGIN_TOL;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_prob_first = '0;
    in_prob_second = '0;
    in_odds_ratio = '0;
    in_odds_infinite = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    corner = '{0, 1, 32768, 65535, 65536, 131071};
    for (int i = 0; i < 6; i++) begin
      b.p1 = corner[i];
      b.p2 = corner[5 - i];
      b.theta = 32'd3 << 16;
      b.inf = 1'b0;
      send_beat(b);
    end
    b.p1 = 20000;
    b.p2 = 50000;
    foreach (corner[i]) begin
      b.inf = 1'b0;
      case (i)
        0: b.theta = 0;
        1: b.theta = 32'h0001_0000;
        2: b.theta = 32'h0001_0001;
        3: b.theta = 32'hFFFF_FFFF;
        4: b.theta = 32'h0000_0001;
        default: begin
          b.theta = 32'h0001_0000;
          b.inf = 1'b1;
        end
      endcase
      send_beat(b);
    end
    b.p1 = 30000;
    b.p2 = 30000;
    b.inf = 1'b0;
    b.theta = 32'h0000_4000;
    send_beat(b);
    b.theta = 32'h0040_0000;
    send_beat(b);

    mts = '{0, 65536, 131071, 300, 1, 0};
    ots = '{0, 65536, 131071, 2000, 1, 0};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        mts[5] = pjp_pkg::PROB_W'($urandom_range(0, 131071));
        ots[5] = pjp_pkg::PROB_W'($urandom_range(0, 131071));
      end
      write_tolerances(mts[ph], ots[ph]);
      for (int k = 0; k < 200; k++) send_beat(rand_beat());
      if (ph == 4) write_tolerances(0, 0);
    end
    for (int k = 0; k < 500; k++) begin
      if (k == 400) quiet = 1'b1;
      send_beat(rand_beat());
    end
    write_tolerances(1, 1);
    for (int k = 0; k < 50; k++) send_beat(rand_beat());
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0)
      $display("plackett_joint_prob_with_tolerances_core test passed");
    else
      $display("plackett_joint_prob_with_tolerances_core test failed");
    $finish;
  end
endmodule

// File: filelist.f
src/pjp_pkg.sv
src/pjp_front.sv
src/pjp_fifo.sv
src/pjp_back.sv
src/plackett_joint_prob_with_tolerances_core.sv
dv/tb.sv
